FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent, reset included.
`define ASSERT_NEXT_ANY(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/pfda_pkg.sv
// ---------------------------------------------------------------------------
// PID controller package
// Widths, register map, status codes and configuration type.
// ---------------------------------------------------------------------------
package pfda_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int FC_FRAC_BITS   = 15;

  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 16;
  localparam int SUM_W   = 32;
  localparam int ERR_W   = SAMPLE_BITS + 1;
  localparam int DIFF_W  = SAMPLE_BITS + 2;
  localparam int P_W     = GAIN_W + 1 + ERR_W;
  localparam int KD_W    = GAIN_W + 1 + DIFF_W;
  localparam int I_W     = GAIN_W + 1 + SUM_W;
  localparam int FCP_W   = GAIN_W + SUM_W;
  localparam int UD_W    = FCP_W + 2;
  localparam int ACC_W   = I_W + 2;

  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_KP = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_KI = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_KD = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_FC = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_UP = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_LO = REG_IDX_W'(5);

  localparam int STAT_W = 2;
  localparam logic [STAT_W-1:0] STAT_NONE  = STAT_W'(0);
  localparam logic [STAT_W-1:0] STAT_UPPER = STAT_W'(1);
  localparam logic [STAT_W-1:0] STAT_LOWER = STAT_W'(2);

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [GAIN_W-1:0]  deriv_filter_coeff;
    logic [DRIVE_W-1:0] drive_upper_limit;
    logic [DRIVE_W-1:0] drive_lower_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:          GAIN_W'(256),
    integ_gain:         GAIN_W'(0),
    deriv_gain:         GAIN_W'(0),
    deriv_filter_coeff: GAIN_W'(0),
    drive_upper_limit:  {1'b0, {(DRIVE_W-1){1'b1}}},
    drive_lower_limit:  {1'b1, {(DRIVE_W-1){1'b0}}}
  };

endpackage

FILE: design/pfda_regs.sv
// ---------------------------------------------------------------------------
// PID controller register file
// APB-style configuration registers with read back.
// ---------------------------------------------------------------------------
module pfda_regs
  import pfda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [REG_IDX_W-1:0] index;
  logic                 wr_en;

  assign pready = 1'b1;
  assign index  = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (index)
        REG_KP:  cfg.prop_gain          <= pwdata[GAIN_W-1:0];
        REG_KI:  cfg.integ_gain         <= pwdata[GAIN_W-1:0];
        REG_KD:  cfg.deriv_gain         <= pwdata[GAIN_W-1:0];
        REG_FC:  cfg.deriv_filter_coeff <= pwdata[GAIN_W-1:0];
        REG_UP:  cfg.drive_upper_limit  <= pwdata[DRIVE_W-1:0];
        REG_LO:  cfg.drive_lower_limit  <= pwdata[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_KP:  prdata = DATA_W'(cfg.prop_gain);
      REG_KI:  prdata = DATA_W'(cfg.integ_gain);
      REG_KD:  prdata = DATA_W'(cfg.deriv_gain);
      REG_FC:  prdata = DATA_W'(cfg.deriv_filter_coeff);
      REG_UP:  prdata = DATA_W'(cfg.drive_upper_limit);
      REG_LO:  prdata = DATA_W'(cfg.drive_lower_limit);
      default: prdata = '0;
    endcase
  end

endmodule

FILE: design/pfda_core.sv
// ---------------------------------------------------------------------------
// PID controller datapath
// Error, integral, filtered derivative, drive sum and clamp, with the
// controller state that closes the loop from one sample to the next.
// ---------------------------------------------------------------------------
module pfda_core
  import pfda_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [SAMPLE_BITS-1:0]    left_sample,
  input  logic [SAMPLE_BITS-1:0]    right_sample,
  input  cfg_t                      cfg,
  output logic signed [DRIVE_W-1:0] drive,
  output logic [STAT_W-1:0]         clamp_status
);

  localparam logic signed [FCP_W:0] FC_HALF =
    (FCP_W+1)'((1 << FC_FRAC_BITS) >> 1);
  localparam logic signed [ACC_W-1:0] GAIN_HALF =
    ACC_W'((1 << GAIN_FRAC_BITS) >> 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic signed [ERR_W-1:0]   last_error;
  logic signed [SUM_W-1:0]   error_sum;
  logic signed [SUM_W-1:0]   filtered_deriv;

  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   new_sum;
  logic signed [KD_W-1:0]    kd_term;
  logic signed [FCP_W-1:0]   fc_prod;
  logic signed [FCP_W:0]     fc_rnd;
  logic signed [FCP_W:0]     fc_sh;
  logic signed [UD_W-1:0]    ud;
  logic [UD_W-SUM_W:0]       ud_hi;
  logic signed [SUM_W-1:0]   new_ud;
  logic signed [P_W-1:0]     p_term;
  logic signed [I_W-1:0]     i_term;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [ACC_W-1:0]   drive_full;
  logic signed [ACC_W-1:0]   upper_x;
  logic signed [ACC_W-1:0]   lower_x;

  always_comb begin
    err  = $signed({1'b0, left_sample}) - $signed({1'b0, right_sample});
    diff = DIFF_W'(err) - DIFF_W'(last_error);

    sum_wide = (SUM_W+1)'(error_sum) + (SUM_W+1)'(last_error);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      new_sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      new_sum = sum_wide[SUM_W-1:0];
    end

    kd_term = KD_W'($signed({1'b0, cfg.deriv_gain})) * KD_W'(diff);
    fc_prod = FCP_W'($signed(cfg.deriv_filter_coeff)) * FCP_W'(filtered_deriv);
    fc_rnd  = (FCP_W+1)'(fc_prod) + FC_HALF;
    fc_sh   = fc_rnd >>> FC_FRAC_BITS;
    ud      = UD_W'(kd_term) + UD_W'(fc_sh);
    ud_hi   = ud[UD_W-1:SUM_W-1];
    if ((&ud_hi) || !(|ud_hi)) begin
      new_ud = ud[SUM_W-1:0];
    end else begin
      new_ud = ud[UD_W-1] ? SUM_MIN : SUM_MAX;
    end

    p_term     = P_W'($signed({1'b0, cfg.prop_gain})) * P_W'(err);
    i_term     = I_W'($signed({1'b0, cfg.integ_gain})) * I_W'(new_sum);
    acc        = ACC_W'(p_term) + ACC_W'(i_term) + ACC_W'(new_ud);
    acc_rnd    = acc + GAIN_HALF;
    drive_full = acc_rnd >>> GAIN_FRAC_BITS;

    upper_x = ACC_W'($signed(cfg.drive_upper_limit));
    lower_x = ACC_W'($signed(cfg.drive_lower_limit));
    if (drive_full > upper_x) begin
      drive        = $signed(cfg.drive_upper_limit);
      clamp_status = STAT_UPPER;
    end else if (drive_full < lower_x) begin
      drive        = $signed(cfg.drive_lower_limit);
      clamp_status = STAT_LOWER;
    end else begin
      drive        = drive_full[DRIVE_W-1:0];
      clamp_status = STAT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error     <= '0;
      error_sum      <= '0;
      filtered_deriv <= '0;
    end else if (step) begin
      last_error     <= err;
      filtered_deriv <= new_ud;
      if (clamp_status == STAT_NONE) begin
        error_sum <= new_sum;
      end
    end
  end

endmodule

FILE: design/pid_filtered_derivative_antiwindup.sv
// ---------------------------------------------------------------------------
// PID controller with filtered derivative and clamping anti-windup
// Takes one left/right sensor sample pair per transfer and returns one
// clamped drive value and a clamp status per transfer.
// ---------------------------------------------------------------------------
// The block accepts one sample pair in every clock cycle while sample_stall
// is low. A sample is held in an input register and its result in the
// output register; the error, integral, filtered derivative, drive sum and
// clamp are computed between the two in one pass of parallel multipliers
// and adders that also updates the controller state, so the state each
// sample leaves is used by the next one. The output register and the input
// register let a new sample be taken while a result still waits. Gains are
// unsigned Q8.8, the filter coefficient is signed Q1.15, and the integral
// and derivative accumulators saturate at the signed 32-bit bounds.
// Configuration writes belong to idle periods.
module pid_filtered_derivative_antiwindup
  import pfda_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic [SAMPLE_BITS-1:0]    left_sample,
  input  logic [SAMPLE_BITS-1:0]    right_sample,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [DRIVE_W-1:0] drive,
  output logic [STAT_W-1:0]         clamp_status
);

  cfg_t                      cfg;
  logic                      in_valid;
  logic [SAMPLE_BITS-1:0]    left_q;
  logic [SAMPLE_BITS-1:0]    right_q;
  logic                      advance;
  logic                      accept;
  logic signed [DRIVE_W-1:0] drive_next;
  logic [STAT_W-1:0]         clamp_status_next;

  assign advance      = in_valid && (!result_valid || !result_stall);
  assign sample_stall = in_valid && !advance;
  assign accept       = sample_valid && !sample_stall;

  pfda_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pfda_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .left_sample  (left_q),
    .right_sample (right_q),
    .cfg          (cfg),
    .drive        (drive_next),
    .clamp_status (clamp_status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_q  <= left_sample;
      right_q <= right_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive        <= drive_next;
      clamp_status <= clamp_status_next;
    end
  end

endmodule

FILE: design/pfda_checker.sv
// ---------------------------------------------------------------------------
// PID controller port checker
// Concurrent checks on the ports of the top level, bound to it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfda_checker
  import pfda_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic [DRIVE_W-1:0] drive,
  input logic [STAT_W-1:0]  clamp_status,
  input logic               pready
);

  logic [DRIVE_W+STAT_W-1:0] result_word;

  assign result_word = {drive, clamp_status};

  `ASSERT_NEXT_ANY(a_reset_empties, clk, rst, !result_valid)

  `ASSERT_ALWAYS(a_status_code, clk, rst, !result_valid || clamp_status <= STAT_LOWER)

  `ASSERT_ALWAYS(a_stall_only_when_full, clk, rst, !sample_stall || (result_valid && result_stall))

  `ASSERT_NEXT(a_result_holds, clk, rst, result_valid && result_stall, $stable(result_word))

  `ASSERT_ALWAYS(a_apb_ready, clk, rst, pready || !sample_valid)

endmodule

bind pid_filtered_derivative_antiwindup pfda_checker u_checker (.*);

FILE: verif/pid_filtered_derivative_antiwindup_tb.sv
// ---------------------------------------------------------------------------
// PID controller testbench
// Writes the gain, filter and limit registers over the APB-style port,
// streams sensor sample pairs with random gaps and output stalls, and checks
// every drive and clamp status transfer against typed expected values or an
// in-bench fixed-point model of the controller.
// ---------------------------------------------------------------------------
module pid_filtered_derivative_antiwindup_tb
  import pfda_pkg::*;
;

  localparam int unsigned NUM_PHASES      = 9;
  localparam int unsigned ITEMS_PER_PHASE = 180;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned TAIL_CYCLES     = 20;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam longint      S32_MAX         = 64'sd2147483647;
  localparam longint      S32_MIN         = -64'sd2147483648;

  localparam logic [REG_IDX_W-1:0] REG_NONE_LO = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_NONE_HI = REG_IDX_W'(7);

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic [STAT_W-1:0]         status;
  } ctrl_out_t;

  typedef enum logic {ROW_WRITE, ROW_PAIR} row_kind_t;

  typedef enum logic [2:0] {
    PAT_UNIFORM, PAT_EXTREME, PAT_BALANCED, PAT_ALTERNATE, PAT_RAMP
  } pattern_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] arg_a;
    logic [15:0] arg_b;
    logic        has_result;
    ctrl_out_t   result;
  } dir_row_t;

  localparam int DIR_LEN = 42;
  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    '{ROW_PAIR,  16'd0,            16'd0,     1'b1, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd4095,         16'd0,     1'b1, '{16'sd4095,  STAT_NONE}},
    '{ROW_PAIR,  16'd0,            16'd4095,  1'b1, '{-16'sd4095, STAT_NONE}},
    '{ROW_PAIR,  16'd4095,         16'd4095,  1'b1, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd2048,         16'd2047,  1'b1, '{16'sd1,     STAT_NONE}},
    '{ROW_PAIR,  16'd1234,         16'd3210,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_KP),      16'hFFFF,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_UP),      16'sd100,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_LO),      -16'sd100, 1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd4095,         16'd0,     1'b1, '{16'sd100,   STAT_UPPER}},
    '{ROW_PAIR,  16'd0,            16'd4095,  1'b1, '{-16'sd100,  STAT_LOWER}},
    '{ROW_PAIR,  16'd0,            16'd0,     1'b1, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_UP),      -16'sd100, 1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_LO),      16'sd100,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd0,            16'd0,     1'b1, '{-16'sd100,  STAT_UPPER}},
    '{ROW_PAIR,  16'd0,            16'd4095,  1'b1, '{16'sd100,   STAT_LOWER}},
    '{ROW_WRITE, 16'(REG_UP),      16'h7FFF,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_LO),      16'h8000,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_KP),      16'd256,   1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_KI),      16'd256,   1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_KD),      16'd256,   1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_FC),      16'h4000,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_NONE_LO), 16'h1234,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_NONE_HI), 16'hFFFF,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd4095,         16'd0,     1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd0,            16'd4095,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd4095,         16'd0,     1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd2000,         16'd2100,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd0,            16'd0,     1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd4095,         16'd4095,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_KP),      16'd0,     1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_KI),      16'd0,     1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_KD),      16'hFFFF,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_WRITE, 16'(REG_FC),      16'h8000,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd4095,         16'd0,     1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd0,            16'd4095,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd4095,         16'd0,     1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd0,            16'd4095,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd4095,         16'd0,     1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd0,            16'd4095,  1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd4095,         16'd0,     1'b0, '{16'sd0,     STAT_NONE}},
    '{ROW_PAIR,  16'd0,            16'd4095,  1'b0, '{16'sd0,     STAT_NONE}}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      sample_valid = 1'b0;
  logic                      sample_stall;
  logic [SAMPLE_BITS-1:0]    left_sample = '0;
  logic [SAMPLE_BITS-1:0]    right_sample = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic signed [DRIVE_W-1:0] drive;
  logic [STAT_W-1:0]         clamp_status;

  cfg_t                    pid_cfg = CFG_RESET;
  logic signed [ERR_W-1:0] pid_prev_err = '0;
  logic signed [SUM_W-1:0] pid_err_sum = '0;
  logic signed [SUM_W-1:0] pid_deriv = '0;

  ctrl_out_t              expected_drives [$];
  ctrl_out_t              oldest;
  int unsigned            mismatches = 0;
  int unsigned            cycle_count = 0;
  int unsigned            stall_mode = 0;
  int unsigned            stall_left = 0;
  logic [SAMPLE_BITS-1:0] ramp_pos = '0;

  pid_filtered_derivative_antiwindup u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .drive        (drive),
    .clamp_status (clamp_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [SUM_W-1:0] clip_s32(input longint v);
    if (v > S32_MAX) return SUM_W'(S32_MAX);
    if (v < S32_MIN) return SUM_W'(S32_MIN);
    return SUM_W'(v);
  endfunction

  function automatic ctrl_out_t advance_pid(input logic [SAMPLE_BITS-1:0] l,
                                            input logic [SAMPLE_BITS-1:0] r);
    longint                  err, fc, upper, lower, ud, acc, drv;
    logic signed [SUM_W-1:0] sum_next, deriv_next;
    ctrl_out_t               res;
    err = longint'(l) - longint'(r);
    fc = longint'($signed(pid_cfg.deriv_filter_coeff));
    upper = longint'($signed(pid_cfg.drive_upper_limit));
    lower = longint'($signed(pid_cfg.drive_lower_limit));
    sum_next = clip_s32(longint'(pid_err_sum) + longint'(pid_prev_err));
    ud = longint'(pid_cfg.deriv_gain) * (err - longint'(pid_prev_err))
         + ((fc * longint'(pid_deriv) + (longint'(1) <<< (FC_FRAC_BITS - 1)))
            >>> FC_FRAC_BITS);
    deriv_next = clip_s32(ud);
    acc = longint'(pid_cfg.prop_gain) * err
          + longint'(pid_cfg.integ_gain) * longint'(sum_next)
          + longint'(deriv_next);
    drv = (acc + (longint'(1) <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
    pid_prev_err = ERR_W'(err);
    pid_deriv = deriv_next;
    if (drv > upper) begin
      res.drive = DRIVE_W'(upper);
      res.status = STAT_UPPER;
    end else if (drv < lower) begin
      res.drive = DRIVE_W'(lower);
      res.status = STAT_LOWER;
    end else begin
      res.drive = DRIVE_W'(drv);
      res.status = STAT_NONE;
      pid_err_sum = sum_next;
    end
    return res;
  endfunction

  function automatic logic [15:0] pick_setting(input logic [REG_IDX_W-1:0] idx,
                                               input int unsigned phase);
    logic        is_gain;
    logic [15:0] top, bottom;
    is_gain = (idx == REG_KP) || (idx == REG_KI) || (idx == REG_KD);
    top = is_gain ? 16'hFFFF : 16'h7FFF;
    bottom = is_gain ? 16'h0000 : 16'h8000;
    if (phase == 0) return top;
    if (phase == 1) return bottom;
    if (phase == 2) begin
      case (idx)
        REG_KP:  return 16'd256;
        REG_KI:  return 16'd1;
        REG_KD:  return 16'hFFFF;
        REG_FC:  return 16'h8000;
        REG_UP:  return 16'h7FFF;
        default: return 16'h8000;
      endcase
    end
    case ($urandom_range(0, 7))
      0:       return top;
      1:       return bottom;
      2, 3:    return is_gain ? 16'($urandom_range(0, 1023))
                              : 16'($urandom_range(0, 4095) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pair(input logic [SAMPLE_BITS-1:0] l,
                           input logic [SAMPLE_BITS-1:0] r,
                           input logic typed, input ctrl_out_t typed_res);
    ctrl_out_t res;
    sample_valid <= 1'b1;
    left_sample <= l;
    right_sample <= r;
    do @(posedge clk); while (!(sample_valid && !sample_stall));
    res = advance_pid(l, r);
    expected_drives.push_back(typed ? typed_res : res);
  endtask

  task automatic hold_off(input int unsigned cycles);
    sample_valid <= 1'b0;
    repeat (cycles) begin
      left_sample <= SAMPLE_BITS'($urandom);
      right_sample <= SAMPLE_BITS'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_KP:  pid_cfg.prop_gain = value;
      REG_KI:  pid_cfg.integ_gain = value;
      REG_KD:  pid_cfg.deriv_gain = value;
      REG_FC:  pid_cfg.deriv_filter_coeff = value;
      REG_UP:  pid_cfg.drive_upper_limit = value;
      REG_LO:  pid_cfg.drive_lower_limit = value;
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0:       result_stall <= 1'b0;
      1:       result_stall <= ($urandom_range(0, 3) == 0);
      2:       result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= (stall_left % 8 < 3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_drives.size() == 0) begin
        $error("unexpected transfer: drive %0d, clamp_status %0d", drive, clamp_status);
        mismatches++;
      end else begin
        oldest = expected_drives.pop_front();
        if (drive !== oldest.drive) begin
          $error("drive: expected %0d, actual %0d", oldest.drive, drive);
          mismatches++;
        end
        if (clamp_status !== oldest.status) begin
          $error("clamp_status: expected %0d, actual %0d", oldest.status, clamp_status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [SAMPLE_BITS-1:0] l, r;
    logic [15:0]            setting [NUM_REGS];
    logic [15:0]            swap_val;
    int unsigned            burst, sent, gap;
    pattern_t               pattern;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_LEN; i++) begin
      if (DIR_ROWS[i].kind == ROW_WRITE) begin
        drain_results();
        reg_write(REG_IDX_W'(DIR_ROWS[i].arg_a), DIR_ROWS[i].arg_b);
      end else begin
        send_pair(SAMPLE_BITS'(DIR_ROWS[i].arg_a), SAMPLE_BITS'(DIR_ROWS[i].arg_b),
                  DIR_ROWS[i].has_result, DIR_ROWS[i].result);
        gap = $urandom_range(0, 3);
        if (gap > 1) hold_off(gap - 1);
      end
    end

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      for (int k = 0; k < NUM_REGS; k++) setting[k] = pick_setting(REG_IDX_W'(k), phase);
      if (phase > 2 && $signed(setting[REG_UP]) < $signed(setting[REG_LO])
          && $urandom_range(0, 3) != 0) begin
        swap_val = setting[REG_UP];
        setting[REG_UP] = setting[REG_LO];
        setting[REG_LO] = swap_val;
      end
      for (int k = 0; k < NUM_REGS; k++) reg_write(REG_IDX_W'(k), setting[k]);

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 24);
        if (phase == 2 && $urandom_range(0, 1) == 0) pattern = PAT_ALTERNATE;
        else pattern = pattern_t'($urandom_range(0, 4));
        for (int unsigned j = 0; j < burst; j++) begin
          case (pattern)
            PAT_EXTREME: begin
              l = $urandom_range(0, 1) ? '1 : '0;
              r = $urandom_range(0, 1) ? '1 : '0;
            end
            PAT_BALANCED: begin
              l = SAMPLE_BITS'($urandom);
              r = l + SAMPLE_BITS'($urandom_range(0, 16)) - SAMPLE_BITS'(8);
            end
            PAT_ALTERNATE: begin
              l = j[0] ? '0 : '1;
              r = j[0] ? '1 : '0;
            end
            PAT_RAMP: begin
              ramp_pos = ramp_pos + SAMPLE_BITS'($urandom_range(1, 40));
              l = ramp_pos;
              r = ~ramp_pos;
            end
            default: begin
              l = SAMPLE_BITS'($urandom);
              r = SAMPLE_BITS'($urandom);
            end
          endcase
          send_pair(l, r, 1'b0, '0);
          sent++;
        end
        if (phase % 3 != 0 && $urandom_range(0, 2) != 0) hold_off($urandom_range(1, 6));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
